// ===== rtl/utfv_pkg.sv =====
package utfv_pkg;

    // byte classes found by the front end
    typedef enum logic [1:0] {
        KIND_ASCII = 2'd0,
        KIND_CONT  = 2'd1,
        KIND_LEAD  = 2'd2,
        KIND_BAD   = 2'd3
    } kind_t;

    localparam int unsigned PEND_W = 3;
    localparam int unsigned MASK_W = 6;

    // classified item handed from front end to back end
    typedef struct packed {
        logic                has_byte;
        logic                last_byte;
        kind_t               kind;
        logic [PEND_W-1:0]   lead_pend;
        logic [MASK_W-1:0]   lead_mask;
        logic [MASK_W-1:0]   payload;
    } cls_item_t;

endpackage

// ===== rtl/utf8_stream_validator.sv =====
// utf8 stream validator
// checks a message, one byte per item, for well-formed utf-8 including
// the old 5- and 6-byte sequences
// input channel: s_tdata carries the byte, s_tuser says the byte is
// meaningful (0 only on an empty closing item), s_tlast ends the message
// output channel: one item per message, m_tdata bit 0 is the verdict
// (1 = well formed), upper bits zero
// path: a closing item passes the front register and the queue, and the
// back end registers its verdict; throughput: one item per cycle unless a
// closing item waits for the output slot, set by the back end state update;
// the front end registers the byte class and a small queue sits between them
// stall: while m_tready is low the verdict holds; bytes that are not last
// keep flowing into the back end, a closing item waits in the queue and
// the input backs up once the queue and front register are full
// reset: aresetn low clears the message state, the valid flags and the queue;
// the first message starts clean
module utf8_stream_validator #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] has_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] is_valid, [7:1] zero
);

    // front to queue
    logic                f_valid;
    logic                f_ready;
    utfv_pkg::cls_item_t f_item;
    // queue to back
    logic                q_valid;
    logic                q_ready;
    utfv_pkg::cls_item_t q_item;

    utfv_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item)
    );

    utfv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    // back end holds the message state and the output register
    utfv_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/utfv_front.sv =====
module utfv_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  logic                 s_tuser,
    output logic                 push_valid,
    input  logic                 push_ready,
    output utfv_pkg::cls_item_t  push_item
);

    logic                valid_reg;
    logic                valid_next;
    utfv_pkg::cls_item_t item_reg;
    utfv_pkg::cls_item_t item_next;
    logic                take;

    assign push_valid = valid_reg;
    assign push_item  = item_reg;
    assign s_tready   = !valid_reg || push_ready;
    assign take       = s_tvalid && s_tready;

    always_comb begin
        item_next           = item_reg;
        valid_next          = valid_reg;
        if (valid_reg && push_ready) begin
            valid_next = 1'b0;
        end
        if (take) begin
            valid_next          = 1'b1;
            item_next.has_byte  = s_tuser;
            item_next.last_byte = s_tlast;
            item_next.payload   = s_tdata[5:0];
            item_next.lead_pend = '0;
            item_next.lead_mask = '0;
            // lead byte decode, longest prefix last
            if (!s_tdata[7]) begin
                item_next.kind = utfv_pkg::KIND_ASCII;
            end else if (s_tdata[7:6] == 2'b10) begin
                item_next.kind = utfv_pkg::KIND_CONT;
            end else if (s_tdata[7:5] == 3'b110) begin
                // overlong two-byte form is rejected outright
                item_next.kind      = (s_tdata[4:1] != 4'd0) ? utfv_pkg::KIND_LEAD
                                                             : utfv_pkg::KIND_BAD;
                item_next.lead_pend = 3'd1;
            end else if (s_tdata[7:4] == 4'b1110) begin
                item_next.kind      = utfv_pkg::KIND_LEAD;
                item_next.lead_pend = 3'd2;
                item_next.lead_mask = (s_tdata[3:0] == 4'd0) ? 6'h20 : 6'h00;
            end else if (s_tdata[7:3] == 5'b11110) begin
                item_next.kind      = utfv_pkg::KIND_LEAD;
                item_next.lead_pend = 3'd3;
                item_next.lead_mask = (s_tdata[2:0] == 3'd0) ? 6'h30 : 6'h00;
            end else if (s_tdata[7:2] == 6'b111110) begin
                item_next.kind      = utfv_pkg::KIND_LEAD;
                item_next.lead_pend = 3'd4;
                item_next.lead_mask = (s_tdata[1:0] == 2'd0) ? 6'h38 : 6'h00;
            end else if (s_tdata[7:1] == 7'b1111110) begin
                item_next.kind      = utfv_pkg::KIND_LEAD;
                item_next.lead_pend = 3'd5;
                item_next.lead_mask = (!s_tdata[0]) ? 6'h3c : 6'h00;
            end else begin
                item_next.kind = utfv_pkg::KIND_BAD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

// ===== rtl/utfv_queue.sv =====
module utfv_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  utfv_pkg::cls_item_t  wr_item,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output utfv_pkg::cls_item_t  rd_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    utfv_pkg::cls_item_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== rtl/utfv_back.sv =====
module utfv_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  utfv_pkg::cls_item_t  q_item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata
);

    logic [utfv_pkg::PEND_W-1:0] pend_reg;
    logic [utfv_pkg::PEND_W-1:0] pend_next;
    logic [utfv_pkg::MASK_W-1:0] mask_reg;
    logic [utfv_pkg::MASK_W-1:0] mask_next;
    logic                        err_reg;
    logic                        err_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        verdict_reg;
    logic                        verdict_next;
    logic                        pop;

    // a closing item needs a free output slot, others never wait
    assign pop      = q_valid && (!q_item.last_byte || !out_valid_reg || m_tready);
    assign q_ready  = pop;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, verdict_reg};

    always_comb begin
        logic                        e;
        logic [utfv_pkg::PEND_W-1:0] p;
        logic [utfv_pkg::MASK_W-1:0] m;
        e              = err_reg;
        p              = pend_reg;
        m              = mask_reg;
        pend_next      = pend_reg;
        mask_next      = mask_reg;
        err_next       = err_reg;
        verdict_next   = verdict_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (pop) begin
            if (q_item.has_byte && !e) begin
                if (p != '0) begin
                    if (q_item.kind != utfv_pkg::KIND_CONT) begin
                        e = 1'b1;
                    end else if ((m != '0) && ((q_item.payload & m) == '0)) begin
                        e = 1'b1;
                    end else begin
                        m = '0;
                        p = p - 1'b1;
                    end
                end else begin
                    unique case (q_item.kind)
                        utfv_pkg::KIND_ASCII: begin
                        end
                        utfv_pkg::KIND_LEAD: begin
                            p = q_item.lead_pend;
                            m = q_item.lead_mask;
                        end
                        default: begin
                            e = 1'b1;
                        end
                    endcase
                end
            end
            if (q_item.last_byte) begin
                out_valid_next = 1'b1;
                verdict_next   = !e && (p == '0);
                err_next       = 1'b0;
                pend_next      = '0;
                mask_next      = '0;
            end else begin
                err_next  = e;
                pend_next = p;
                mask_next = m;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= '0;
            mask_reg      <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_reg      <= pend_next;
            mask_reg      <= mask_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
        verdict_reg <= verdict_next;
    end

endmodule

// ===== rtl/utfv_checker.sv =====
module utfv_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // closing items accepted but whose verdict is not yet taken
    logic [3:0] open_reg;
    logic       s_close;
    logic       m_take;

    assign s_close = s_tvalid && s_tready && s_tlast;
    assign m_take  = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else if (s_close && !m_take) begin
            open_reg <= open_reg + 1'b1;
        end else if (m_take && !s_close) begin
            open_reg <= open_reg - 1'b1;
        end
    end

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("verdict valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("verdict dropped or changed while stalled");

    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> open_reg != 4'd0)
        else $error("verdict without a closing item");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:1] == 7'd0)
        else $error("unused verdict bits not zero");

endmodule

bind utf8_stream_validator utfv_checker u_utfv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
